@@ sv/assert_macros.svh @@
// Assertion macros used by the allocator top level.
// Expects signals named clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define OTIA_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("allocator check failed in the same cycle");

// Consequent checked in the cycle after the antecedent.
`define OTIA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("allocator check failed one cycle later");

`endif

@@ sv/otia_pkg.sv @@
// Types and codes for the owner-tagged id allocator.
// No dependencies; used by otia_seq and the top level.
`default_nettype none

package otia_pkg;

    localparam int TAG_W   = 20;
    localparam int CTX_W   = 32;
    localparam int ENTRY_W = CTX_W + TAG_W;

    localparam logic [4:0] IDS_IN_USE_RESET = 5'd16;

    localparam logic [1:0] KIND_GRAB    = 2'd0;
    localparam logic [1:0] KIND_PUT     = 2'd1;
    localparam logic [1:0] KIND_RELEASE = 2'd2;
    localparam logic [1:0] KIND_INVALID = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOFREE  = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    localparam logic [3:0] GRANT_NONE = 4'hF;

    typedef struct packed {
        logic [1:0]       kind;
        logic [3:0]       entry_index;
        logic [CTX_W-1:0] context_number;
        logic [TAG_W-1:0] owner_tag;
    } req_t;

    typedef struct packed {
        logic       done;
        logic [1:0] status;
        logic [3:0] granted_index;
        logic [4:0] released_count;
    } rsp_t;

endpackage

`default_nettype wire

@@ sv/otia_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module otia_ram #(
    parameter int WIDTH = 52,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ sv/otia_seq.sv @@
// Request sequencer: owned flags, grab scan and release scan over the entry RAM.
// Depends on otia_pkg; drives the entry RAM ports of otia_ram.
`default_nettype none

module otia_seq #(
    parameter int NUM_ENTRIES = 16
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    input  wire otia_pkg::req_t                   req,
    input  wire logic [4:0]                       ids_in_use,
    output logic                                  busy,
    output logic                                  ram_we,
    output logic      [$clog2(NUM_ENTRIES)-1:0]   ram_waddr,
    output logic      [otia_pkg::ENTRY_W-1:0]     ram_wdata,
    output logic      [$clog2(NUM_ENTRIES)-1:0]   ram_raddr,
    input  wire logic [otia_pkg::ENTRY_W-1:0]     ram_rdata,
    output otia_pkg::rsp_t                        rsp
);

    localparam int IW = $clog2(NUM_ENTRIES);
    localparam int CW = $clog2(NUM_ENTRIES + 1);
    localparam int LW = (CW > 5) ? CW : 5;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_GRAB = 2'd1;
    localparam logic [1:0] S_REL  = 2'd2;

    logic [1:0]                   state_reg, state_next;
    logic [NUM_ENTRIES-1:0]       owned_reg, owned_next;
    logic [CW-1:0]                scan_reg, scan_next;
    logic [CW-1:0]                limit_reg, limit_next;
    logic [CW-1:0]                count_reg, count_next;
    logic [otia_pkg::TAG_W-1:0]   tag_reg, tag_next;
    logic [otia_pkg::CTX_W-1:0]   ctx_reg, ctx_next;
    logic                         cmp_vld_reg, cmp_vld_next;
    logic [IW-1:0]                cmp_idx_reg, cmp_idx_next;
    otia_pkg::rsp_t               rsp_reg, rsp_next;

    logic          accept;
    logic [CW-1:0] limit_w;
    logic          put_in_range;
    logic [IW-1:0] put_idx;
    logic [IW-1:0] scan_idx;
    logic          hit;
    logic [CW-1:0] rel_sum;

    assign accept       = start && (state_reg == S_IDLE);
    assign busy         = (state_reg != S_IDLE);
    assign limit_w      = (LW'(ids_in_use) > LW'(NUM_ENTRIES)) ? CW'(NUM_ENTRIES)
                                                               : CW'(ids_in_use);
    assign put_in_range = LW'(req.entry_index) < LW'(NUM_ENTRIES);
    assign put_idx      = IW'(req.entry_index);
    assign scan_idx     = scan_reg[IW-1:0];
    assign hit          = cmp_vld_reg && owned_reg[cmp_idx_reg]
                          && (ram_rdata[otia_pkg::TAG_W-1:0] == tag_reg);
    assign rel_sum      = count_reg + CW'(hit);

    assign ram_waddr = scan_idx;
    assign ram_wdata = {ctx_reg, tag_reg};
    assign ram_raddr = scan_idx;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next   = state_reg;
        owned_next   = owned_reg;
        scan_next    = scan_reg;
        limit_next   = limit_reg;
        count_next   = count_reg;
        tag_next     = tag_reg;
        ctx_next     = ctx_reg;
        cmp_vld_next = 1'b0;
        cmp_idx_next = cmp_idx_reg;
        rsp_next     = '0;
        ram_we       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    tag_next   = req.owner_tag;
                    ctx_next   = req.context_number;
                    scan_next  = '0;
                    count_next = '0;
                    case (req.kind)
                        otia_pkg::KIND_GRAB:
                        begin
                            limit_next = limit_w;
                            state_next = S_GRAB;
                        end
                        otia_pkg::KIND_PUT:
                        begin
                            rsp_next.done   = 1'b1;
                            rsp_next.status = otia_pkg::ST_OK;
                            if (put_in_range)
                            begin
                                rsp_next.released_count = 5'(owned_reg[put_idx]);
                                owned_next[put_idx]     = 1'b0;
                            end
                        end
                        otia_pkg::KIND_RELEASE:
                        begin
                            state_next = S_REL;
                        end
                        default:
                        begin
                            rsp_next.done   = 1'b1;
                            rsp_next.status = otia_pkg::ST_INVALID;
                        end
                    endcase
                end
            end
            S_GRAB:
            begin
                if (scan_reg == limit_reg)
                begin
                    rsp_next.done          = 1'b1;
                    rsp_next.status        = otia_pkg::ST_NOFREE;
                    rsp_next.granted_index = otia_pkg::GRANT_NONE;
                    state_next             = S_IDLE;
                end
                else if (!owned_reg[scan_idx])
                begin
                    // claim the entry and record its owner in the RAM
                    owned_next[scan_idx]   = 1'b1;
                    ram_we                 = 1'b1;
                    rsp_next.done          = 1'b1;
                    rsp_next.status        = otia_pkg::ST_OK;
                    rsp_next.granted_index = 4'(scan_reg);
                    state_next             = S_IDLE;
                end
                else
                begin
                    scan_next = scan_reg + CW'(1);
                end
            end
            S_REL:
            begin
                // read one entry a cycle; compare its tag in the cycle after the read
                if (scan_reg != CW'(NUM_ENTRIES))
                begin
                    scan_next    = scan_reg + CW'(1);
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = scan_idx;
                end
                if (hit)
                begin
                    owned_next[cmp_idx_reg] = 1'b0;
                end
                count_next = rel_sum;
                if (cmp_vld_reg && (cmp_idx_reg == IW'(NUM_ENTRIES - 1)))
                begin
                    rsp_next.done           = 1'b1;
                    rsp_next.status         = otia_pkg::ST_OK;
                    rsp_next.released_count = 5'(rel_sum);
                    cmp_vld_next            = 1'b0;
                    state_next              = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            owned_reg   <= '0;
            cmp_vld_reg <= 1'b0;
            rsp_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            owned_reg   <= owned_next;
            cmp_vld_reg <= cmp_vld_next;
            rsp_reg     <= rsp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg    <= scan_next;
        limit_reg   <= limit_next;
        count_reg   <= count_next;
        tag_reg     <= tag_next;
        ctx_reg     <= ctx_next;
        cmp_idx_reg <= cmp_idx_next;
    end

endmodule

`default_nettype wire

@@ sv/owner_tagged_id_allocator_top.sv @@
// Top level of the owner-tagged id allocator: config register, sequencer, entry RAM.
// Depends on otia_pkg, otia_seq, otia_ram and assert_macros.svh.
//
// Usage:
//   A request beat is taken at a rising edge with start high and busy low.
//   kind selects grab (0), put by index (1), release all of an owner (2);
//   any other kind is answered as invalid. Every request gives one result,
//   shown for exactly one cycle with done high; the receiver cannot stall it.
//   Put and invalid requests: done in the cycle after the accepting edge,
//   busy stays low, so a new request may follow at once.
//   Grab: the scan walks the owned flags one entry per cycle from entry 0
//   over the first min(ids_in_use, NUM_ENTRIES) entries; the first free
//   entry is claimed and granted, a full pool is answered with no-free status.
//   Release: one entry RAM read per cycle over all NUM_ENTRIES entries plus
//   one compare stage; done follows the compare of the last entry.
//   The RAM read port sets this rate. busy is high while a scan runs.
//   cfg_we writes ids_in_use (reset 16) from cfg_wdata; write it only while
//   no request is in flight.
//   Reset clears all owned flags at once and sets ids_in_use to 16; no
//   clearing pass runs, the first request may be taken right after reset.
`default_nettype none
`include "assert_macros.svh"

module owner_tagged_id_allocator_top #(
    parameter int NUM_ENTRIES = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  kind,
    input  wire logic [3:0]  entry_index,
    input  wire logic [31:0] context_number,
    input  wire logic [19:0] owner_tag,
    output logic             done,
    output logic      [1:0]  status,
    output logic      [3:0]  granted_index,
    output logic      [4:0]  released_count,
    input  wire logic        cfg_we,
    input  wire logic [4:0]  cfg_wdata
);

    localparam int AW = $clog2(NUM_ENTRIES);

    logic [4:0]                     ids_in_use_reg;
    otia_pkg::req_t                 req;
    otia_pkg::rsp_t                 rsp;
    logic                           ram_we;
    logic [AW-1:0]                  ram_waddr;
    logic [otia_pkg::ENTRY_W-1:0]   ram_wdata;
    logic [AW-1:0]                  ram_raddr;
    logic [otia_pkg::ENTRY_W-1:0]   ram_rdata;
    logic                           acc_put;
    logic                           acc_invalid;
    logic                           nofree_done;
    logic                           nofree_shape;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ids_in_use_reg <= otia_pkg::IDS_IN_USE_RESET;
        end
        else if (cfg_we)
        begin
            ids_in_use_reg <= cfg_wdata;
        end
    end

    assign req.kind           = kind;
    assign req.entry_index    = entry_index;
    assign req.context_number = context_number;
    assign req.owner_tag      = owner_tag;

    otia_seq #(
        .NUM_ENTRIES (NUM_ENTRIES)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .req        (req),
        .ids_in_use (ids_in_use_reg),
        .busy       (busy),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata),
        .rsp        (rsp)
    );

    otia_ram #(
        .WIDTH (otia_pkg::ENTRY_W),
        .DEPTH (NUM_ENTRIES)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign done           = rsp.done;
    assign status         = rsp.status;
    assign granted_index  = rsp.granted_index;
    assign released_count = rsp.released_count;

    assign acc_put      = start && !busy && (kind == otia_pkg::KIND_PUT);
    assign acc_invalid  = start && !busy && (kind == otia_pkg::KIND_INVALID);
    assign nofree_done  = done && (status == otia_pkg::ST_NOFREE);
    assign nofree_shape = (granted_index == otia_pkg::GRANT_NONE) && (released_count == 5'd0);

    `OTIA_ASSERT_NEXT(a_invalid_answered, acc_invalid, done && status == otia_pkg::ST_INVALID)
    `OTIA_ASSERT_NEXT(a_put_answered, acc_put, done && !busy && status == otia_pkg::ST_OK)
    `OTIA_ASSERT_SAME(a_nofree_shape, nofree_done, nofree_shape)

endmodule

`default_nettype wire
